### hw/rtl/cdq_pkg.sv
package cdq_pkg;

  // Field widths fixed by the operation format.
  localparam int ModeW  = 2;
  localparam int ValueW = 32;
  localparam int CapW   = 5;

  // Capacity register value after reset.
  localparam logic [CapW-1:0] CapReset = 5'd16;

  // Value reported for the front and back of an empty deque.
  localparam logic signed [ValueW-1:0] EmptyValue = '1;

  typedef enum logic [ModeW-1:0] {
    ModePushFront = 2'd0,
    ModePushBack  = 2'd1,
    ModePopFront  = 2'd2,
    ModePopBack   = 2'd3
  } mode_e;

endpackage

### hw/rtl/cdq_if.sv
// Operation channel into the deque.
interface cdq_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [cdq_pkg::ModeW-1:0]             mode;
  logic signed [cdq_pkg::ValueW-1:0]     value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

// Result channel out of the deque.
interface cdq_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  ok;
  logic signed [cdq_pkg::ValueW-1:0]     front_value;
  logic signed [cdq_pkg::ValueW-1:0]     back_value;
  logic                                  is_empty;
  logic                                  is_full;

  modport source (output valid, output ok, output front_value, output back_value,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input ok, input front_value, input back_value,
                  input is_empty, input is_full, output ready);
endinterface

// Capacity register write channel.
interface cdq_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [cdq_pkg::CapW-1:0]              capacity;

  modport source (output valid, output capacity, input ready);
  modport sink   (input valid, input capacity, output ready);
endinterface

### hw/rtl/circular_deque_unit.sv
// Channel   Direction  Word contents
// -------   ---------  -------------------------------------------------
// in_i      sink       mode (push front/back, pop front/back), value
// out_o     source     ok, front_value, back_value, is_empty, is_full
// cfg_i     sink       capacity (always ready)
//
// Every accepted word gives one result word. The read stage registers the
// RAM data and then passes the result into the output register, where it
// can be taken; with the output side ready the unit takes one word per
// cycle. The store RAM's registered read of the new front and back entries
// forms a second stage behind the pointer update.
// Reset clears the pointers, the entry count and the valid flags and loads
// capacity 16; the store itself is not cleared, since only written entries
// are ever read. When the output register is held, the read stage holds its
// RAM data and in_i drops ready until the output side drains.
module circular_deque_unit #(
  parameter int DEPTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cdq_in_if.sink       in_i,
  cdq_out_if.source    out_o,
  cdq_cfg_if.sink      cfg_i
);

  localparam int IdxW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);
  localparam int CmpW = (CntW > cdq_pkg::CapW) ? CntW : cdq_pkg::CapW;
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(DEPTH - 1);
  localparam logic [CmpW-1:0] DepthCmp = CmpW'(DEPTH);

  // Ring pointer steps; the ring always wraps over the full store depth.
  function automatic logic [IdxW-1:0] wrap_inc(input logic [IdxW-1:0] idx);
    return (idx == LastIdx) ? '0 : idx + IdxW'(1);
  endfunction

  function automatic logic [IdxW-1:0] wrap_dec(input logic [IdxW-1:0] idx);
    return (idx == '0) ? LastIdx : idx - IdxW'(1);
  endfunction

  // Configuration.
  logic [cdq_pkg::CapW-1:0] cap_q, cap_d;
  logic [CmpW-1:0]          cap_ext;
  logic [CmpW-1:0]          cap_sat;
  logic [CntW-1:0]          cap_eff;

  // Deque state.
  logic [IdxW-1:0] head_q, head_d;
  logic [IdxW-1:0] tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;

  // Operation decode.
  logic              in_fire;
  logic              cur_full, cur_empty;
  logic              op_ok;
  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr;
  cdq_pkg::mode_e    op_mode;

  // Read stage: holds the RAM data read when the word is accepted.
  logic                               s1_valid_q, s1_valid_d;
  logic                               s1_ok_q;
  logic                               s1_empty_q;
  logic                               s1_full_q;
  logic                               s1_fwd_front_q;
  logic                               s1_fwd_back_q;
  logic signed [cdq_pkg::ValueW-1:0]  s1_value_q;
  logic                               s1_adv;
  logic [cdq_pkg::ValueW-1:0]         ram_rdata_a, ram_rdata_b;
  logic signed [cdq_pkg::ValueW-1:0]  front_sel, back_sel;

  // Output register.
  logic                               out_valid_q, out_valid_d;
  logic                               out_ok_q;
  logic                               out_empty_q;
  logic                               out_full_q;
  logic signed [cdq_pkg::ValueW-1:0]  out_front_q;
  logic signed [cdq_pkg::ValueW-1:0]  out_back_q;
  logic                               out_free;

  // ---------------------------------------------------------------------
  // Capacity register and its effective value: zero counts as one, and
  // anything above the store depth is clipped to the depth.
  // ---------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;
  assign cap_d       = (cfg_i.valid) ? cfg_i.capacity : cap_q;

  always_comb begin
    cap_ext = CmpW'(cap_q);
    cap_sat = (cap_ext > DepthCmp) ? DepthCmp : cap_ext;
    if (cap_sat == '0) begin
      cap_sat = CmpW'(1);
    end
    cap_eff = CntW'(cap_sat);
  end

  // ---------------------------------------------------------------------
  // Pointer update. A push moves its pointer first and then writes the
  // entry it points at; a push into an empty deque lines the tail up with
  // the head and writes there. A pop moves its pointer away, except that
  // popping the last entry lines the tail up with the head.
  // ---------------------------------------------------------------------
  assign in_fire   = in_i.valid & in_i.ready;
  assign op_mode   = cdq_pkg::mode_e'(in_i.mode);
  assign cur_full  = (count_q >= cap_eff);
  assign cur_empty = (count_q == '0);

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    op_ok     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = head_q;
    case (op_mode)
      cdq_pkg::ModePushFront: begin
        if (!cur_full) begin
          op_ok = 1'b1;
          if (cur_empty) begin
            tail_d = head_q;
          end else begin
            head_d = wrap_dec(head_q);
          end
          ram_we    = in_fire;
          ram_waddr = head_d;
          count_d   = count_q + CntW'(1);
        end
      end
      cdq_pkg::ModePushBack: begin
        if (!cur_full) begin
          op_ok = 1'b1;
          if (cur_empty) begin
            tail_d = head_q;
          end else begin
            tail_d = wrap_inc(tail_q);
          end
          ram_we    = in_fire;
          ram_waddr = tail_d;
          count_d   = count_q + CntW'(1);
        end
      end
      cdq_pkg::ModePopFront: begin
        if (!cur_empty) begin
          op_ok = 1'b1;
          if (count_q == CntW'(1)) begin
            tail_d = head_q;
          end else begin
            head_d = wrap_inc(head_q);
          end
          count_d = count_q - CntW'(1);
        end
      end
      cdq_pkg::ModePopBack: begin
        if (!cur_empty) begin
          op_ok = 1'b1;
          if (count_q == CntW'(1)) begin
            tail_d = head_q;
          end else begin
            tail_d = wrap_dec(tail_q);
          end
          count_d = count_q - CntW'(1);
        end
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Store. The new front and back entries are read in the same cycle as
  // the push writes; the RAM returns old data on a same-address collision,
  // so the read stage forwards the pushed word for that side.
  // ---------------------------------------------------------------------
  cdq_ram #(
    .Width (cdq_pkg::ValueW),
    .Depth (DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (in_i.value),
    .re_i      (in_fire),
    .raddr_a_i (head_d),
    .raddr_b_i (tail_d),
    .rdata_a_o (ram_rdata_a),
    .rdata_b_o (ram_rdata_b)
  );

  // ---------------------------------------------------------------------
  // Handshake. The read stage moves on when the output register is empty
  // or being drained; new words enter when the read stage can move.
  // ---------------------------------------------------------------------
  assign out_free    = !out_valid_q || out_o.ready;
  assign s1_adv      = s1_valid_q && out_free;
  assign in_i.ready  = !s1_valid_q || s1_adv;
  assign s1_valid_d  = in_fire || (s1_valid_q && !s1_adv);
  assign out_valid_d = s1_adv || (out_valid_q && !out_o.ready);

  always_comb begin
    if (s1_empty_q) begin
      front_sel = cdq_pkg::EmptyValue;
      back_sel  = cdq_pkg::EmptyValue;
    end else begin
      front_sel = s1_fwd_front_q ? s1_value_q : $signed(ram_rdata_a);
      back_sel  = s1_fwd_back_q  ? s1_value_q : $signed(ram_rdata_b);
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= cdq_pkg::CapReset;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cap_q       <= cap_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        head_q  <= head_d;
        tail_q  <= tail_d;
        count_q <= count_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_ok_q        <= op_ok;
      s1_empty_q     <= (count_d == '0);
      s1_full_q      <= (count_d >= cap_eff);
      s1_fwd_front_q <= ram_we && (ram_waddr == head_d);
      s1_fwd_back_q  <= ram_we && (ram_waddr == tail_d);
      s1_value_q     <= in_i.value;
    end
    if (s1_adv) begin
      out_ok_q    <= s1_ok_q;
      out_empty_q <= s1_empty_q;
      out_full_q  <= s1_full_q;
      out_front_q <= front_sel;
      out_back_q  <= back_sel;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.ok          = out_ok_q;
  assign out_o.front_value = out_front_q;
  assign out_o.back_value  = out_back_q;
  assign out_o.is_empty    = out_empty_q;
  assign out_o.is_full     = out_full_q;

`ifndef SYNTHESIS
  // With at most one entry, front and back are the same slot.
  a_single_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= CntW'(1)) |-> (head_q == tail_q))
    else $error("head and tail differ with at most one entry");

  // The entry count never passes the store depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(count_q) <= DepthCmp)
    else $error("entry count above store depth");

  // A refused operation leaves the deque untouched.
  a_refused_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !op_ok) |=> ($stable(count_q) && $stable(head_q) && $stable(tail_q)))
    else $error("refused operation changed the deque");

  // A held read stage keeps its RAM data.
  a_read_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> ($stable(ram_rdata_a) && $stable(ram_rdata_b)))
    else $error("read data changed while the read stage was held");
`endif

endmodule

### hw/rtl/cdq_ram.sv
// Simple dual-read RAM: one write port, two read ports sharing one read
// enable, registered read data (old data on a same-address read and write).
module cdq_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule
